[rtl/core/hdc_pkg.sv]
// Shared types, codes and helpers for the HTTP body dechunker.
package hdc_pkg;

    localparam int unsigned OCTET_W = 8;
    localparam int unsigned CLEN_W  = 48;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned HEX_W   = 5;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    localparam logic [MODE_W-1:0] MODE_LENGTH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHUNKED = 2'd1;

    localparam logic [OCTET_W-1:0] CH_LF    = 8'h0A;
    localparam logic [OCTET_W-1:0] CH_CR    = 8'h0D;
    localparam logic [OCTET_W-1:0] CH_SPACE = 8'h20;
    localparam logic [OCTET_W-1:0] CH_TAB   = 8'h09;

    localparam logic [HEX_W-1:0] HEX_BASE          = 5'd16;
    localparam logic [HEX_W-1:0] HEX_LETTER_OFFSET = 5'd10;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OVERFLOW   = 2'd1,
        ST_AFTER_DONE = 2'd2
    } t_status;

    typedef enum logic [7:0] {
        PH_DONE     = 8'b0000_0001,
        PH_LENGTH   = 8'b0000_0010,
        PH_CLOSE    = 8'b0000_0100,
        PH_SIZE     = 8'b0000_1000,
        PH_EXT      = 8'b0001_0000,
        PH_DATA     = 8'b0010_0000,
        PH_ENDCHUNK = 8'b0100_0000,
        PH_TRAILER  = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic                payload_valid;
        logic [OCTET_W-1:0]  payload_byte;
        logic                body_done;
        t_status             status;
    } t_result;

    // 0..15 for a hex digit, HEX_BASE otherwise
    function automatic logic [HEX_W-1:0] hex_value(input logic [OCTET_W-1:0] c);
        logic [HEX_W-1:0] v;
        v = HEX_BASE;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = HEX_W'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = HEX_W'(c - 8'h41) + HEX_LETTER_OFFSET;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = HEX_W'(c - 8'h61) + HEX_LETTER_OFFSET;
        end
        return v;
    endfunction

endpackage

[rtl/core/hdc_step.sv]
// Next-state and result logic for one beat of the body dechunker.
module hdc_step #(
    parameter int unsigned LENGTH_BITS = 48
) (
    input  logic                          i_action,
    input  logic [hdc_pkg::OCTET_W-1:0]   i_octet,
    input  logic [hdc_pkg::MODE_W-1:0]    i_body_mode,
    input  logic [hdc_pkg::CLEN_W-1:0]    i_content_length,
    input  hdc_pkg::t_phase               i_phase,
    input  logic [LENGTH_BITS-1:0]        i_left,
    input  logic                          i_line,
    output hdc_pkg::t_phase               o_phase,
    output logic [LENGTH_BITS-1:0]        o_left,
    output logic                          o_line,
    output hdc_pkg::t_result              o_result
);
    import hdc_pkg::*;

    logic [LENGTH_BITS-1:0] w_len;
    logic [LENGTH_BITS-1:0] w_dec;
    logic [HEX_W-1:0]       w_digit;
    logic                   w_valid;
    t_status                w_status;
    t_phase                 w_phase;

    assign w_len     = LENGTH_BITS'(i_content_length);
    assign w_dec     = i_left - LENGTH_BITS'(1);
    assign w_digit   = hex_value(i_octet);

    always_comb begin
        w_phase  = i_phase;
        o_left   = i_left;
        o_line   = i_line;
        w_valid  = 1'b0;
        w_status = ST_OK;
        if (i_action == ACT_START) begin
            o_line = 1'b0;
            if (i_body_mode == MODE_LENGTH) begin
                o_left  = w_len;
                w_phase = (w_len == '0) ? PH_DONE : PH_LENGTH;
            end else if (i_body_mode == MODE_CHUNKED) begin
                o_left  = '0;
                w_phase = PH_SIZE;
            end else begin
                o_left  = '0;
                w_phase = PH_CLOSE;
            end
        end else begin
            unique case (i_phase)
                PH_DONE: begin
                    w_status = ST_AFTER_DONE;
                end
                PH_LENGTH: begin
                    w_valid = 1'b1;
                    o_left  = w_dec;
                    if (w_dec == '0) w_phase = PH_DONE;
                end
                PH_CLOSE: begin
                    w_valid = 1'b1;
                end
                PH_SIZE: begin
                    if (w_digit < HEX_BASE) begin
                        // saturate when the next digit would shift out set bits
                        if (i_left[LENGTH_BITS-1 -: 4] != 4'd0) begin
                            o_left   = '1;
                            w_status = ST_OVERFLOW;
                        end else begin
                            o_left = {i_left[LENGTH_BITS-5:0], w_digit[3:0]};
                        end
                    end else if (!(i_left == '0 &&
                                   (i_octet == CH_SPACE || i_octet == CH_TAB))) begin
                        // a terminating byte other than LF is the first byte of the extension line
                        w_phase = PH_EXT;
                        if (i_octet == CH_LF) begin
                            if (i_left == '0) begin
                                o_line  = 1'b0;
                                w_phase = PH_TRAILER;
                            end else begin
                                w_phase = PH_DATA;
                            end
                        end
                    end
                end
                PH_EXT: begin
                    if (i_octet == CH_LF) begin
                        if (i_left == '0) begin
                            o_line  = 1'b0;
                            w_phase = PH_TRAILER;
                        end else begin
                            w_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    w_valid = 1'b1;
                    o_left  = w_dec;
                    if (w_dec == '0) w_phase = PH_ENDCHUNK;
                end
                PH_ENDCHUNK: begin
                    if (i_octet == CH_LF) begin
                        o_left  = '0;
                        w_phase = PH_SIZE;
                    end
                end
                PH_TRAILER: begin
                    if (i_octet == CH_LF) begin
                        if (!i_line) w_phase = PH_DONE;
                        o_line = 1'b0;
                    end else if (i_octet != CH_CR) begin
                        o_line = 1'b1;
                    end
                end
                default: begin
                    w_phase = PH_DONE;
                end
            endcase
        end
    end

    assign o_phase                = w_phase;
    assign o_result.payload_valid = w_valid;
    assign o_result.payload_byte  = w_valid ? i_octet : '0;
    assign o_result.body_done     = (w_phase == PH_DONE);
    assign o_result.status        = w_status;

endmodule

[rtl/core/http_body_dechunker.sv]
// HTTP message body extractor: length, chunked and until-close body modes.
// Each accepted input beat yields its result beat from a register in the next cycle.
// Throughput: one beat per cycle; set by the single result register, which
// accepts a new beat whenever it is empty or its beat is taken in the same cycle.
// Reset (synchronous, active low): phase goes to done, byte count and line flag
// clear, no result pending.
module http_body_dechunker #(
    parameter int unsigned LENGTH_BITS = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [hdc_pkg::OCTET_W-1:0]   i_octet,
    input  logic [hdc_pkg::MODE_W-1:0]    i_body_mode,
    input  logic [hdc_pkg::CLEN_W-1:0]    i_content_length,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_payload_valid,
    output logic [hdc_pkg::OCTET_W-1:0]   o_payload_byte,
    output logic                          o_body_done,
    output logic [1:0]                    o_status
);
    import hdc_pkg::*;

    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [LENGTH_BITS-1:0] r_left;
    logic [LENGTH_BITS-1:0] n_left;
    logic                   r_line;
    logic                   n_line;
    logic                   r_out_valid;
    t_result                r_result;
    t_result                n_result;
    logic                   w_accept;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    hdc_step #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_step (
        .i_action         (i_action),
        .i_octet          (i_octet),
        .i_body_mode      (i_body_mode),
        .i_content_length (i_content_length),
        .i_phase          (r_phase),
        .i_left           (r_left),
        .i_line           (r_line),
        .o_phase          (n_phase),
        .o_left           (n_left),
        .o_line           (n_line),
        .o_result         (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DONE;
            r_left      <= '0;
            r_line      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase     <= n_phase;
                r_left      <= n_left;
                r_line      <= n_line;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload holds while a beat waits downstream
    always_ff @(posedge i_clk) begin
        if (w_accept) r_result <= n_result;
    end

    assign o_valid         = r_out_valid;
    assign o_payload_valid = r_result.payload_valid;
    assign o_payload_byte  = r_result.payload_byte;
    assign o_body_done     = r_result.body_done;
    assign o_status        = r_result.status;

    // done flag of the pending beat tracks the live phase
    a_done_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_body_done == (r_phase == PH_DONE)))
        else $error("body_done disagrees with phase");

    // a payload byte never carries an error status
    a_payload_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_payload_valid) |-> (o_status == ST_OK))
        else $error("payload beat with nonzero status");

    // a byte that arrives once the body is complete is flagged
    a_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action == ACT_BYTE && r_phase == PH_DONE)
        |=> (o_valid && o_status == ST_AFTER_DONE && !o_payload_valid))
        else $error("byte after done not flagged");

endmodule
